### hw/rtl/qru_pkg.sv
// ----------------------------------------------------------------------------
// qru_pkg
// Shared types, constants and operand selection for the quaternion rotation
// unit: input and result formats, queue command format, and the per-lane
// product/bias table that the back end feeds to its multiplier array.
// ----------------------------------------------------------------------------
package qru_pkg;

  // Fixed point format of all quaternion components.
  localparam int FRAC_BITS = 14;

  // Accumulator width: four doubled 32-bit products plus a bias that can
  // reach 2^(2*FRAC_BITS) or a component shifted up by FRAC_BITS.
  localparam int ACC_W_A = 36;
  localparam int ACC_W_B = 2 * FRAC_BITS + 3;
  localparam int ACC_W_C = FRAC_BITS + 18;
  localparam int ACC_W_AB = (ACC_W_A > ACC_W_B) ? ACC_W_A : ACC_W_B;
  localparam int ACC_W = (ACC_W_AB > ACC_W_C) ? ACC_W_AB : ACC_W_C;

  // Width of an accumulator after the rounding shift.
  localparam int RND_W = ACC_W - FRAC_BITS;

  // Command queue between front and back end (depth is a power of two).
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Index of the final matrix row produced by a rotation request.
  localparam logic [1:0] LAST_ROW = 2'd2;

  typedef logic signed [15:0] q_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // Accumulator constants.
  localparam acc_t ONE_SQ = ACC_W'(1) <<< (2 * FRAC_BITS);
  localparam acc_t DIAG_BIAS = -ONE_SQ;
  localparam acc_t RND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

  // Operation codes carried by func.
  typedef enum logic [1:0] {
    OP_PROD = 2'd0,
    OP_CONJ = 2'd1,
    OP_ROT  = 2'd2
  } op_t;

  // Input transaction.
  typedef struct packed {
    logic [1:0] func;
    q_t         a_real;
    q_t         a_i;
    q_t         a_j;
    q_t         a_k;
    q_t         b_real;
    q_t         b_i;
    q_t         b_j;
    q_t         b_k;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    q_t         out_0;
    q_t         out_1;
    q_t         out_2;
    q_t         out_3;
    logic [1:0] row_index;
    logic       last;
    logic       saturated;
  } out_item_t;

  // Classified command held in the queue; index 0 is the real part.
  typedef struct packed {
    op_t           op;
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
  } cmd_t;

  // Result tag that rides along the back-end pipeline.
  typedef struct packed {
    logic [1:0] row;
    logic       last;
  } meta_t;

  // Operands for one result: four lanes of four products each, a sign per
  // product, a doubling flag and a bias per lane.
  typedef struct packed {
    logic [3:0][3:0][15:0] x;
    logic [3:0][3:0][15:0] y;
    logic [3:0][3:0]       neg;
    logic                  dbl;
    logic [3:0][ACC_W-1:0] bias;
  } opnd_t;

  // Queue flow control between front and back end.
  typedef struct packed {
    logic full;
    logic vld;
  } q_stat_t;

  // Build the operand set for one result of a command.
  function automatic opnd_t build_opnd(cmd_t cmd, logic [1:0] row);
    opnd_t o;
    acc_t  ext;
    int    i;
    int    k;
    int    nxt;
    o = '0;
    case (cmd.op)
      OP_PROD: begin
        // Real lane.
        o.x[0] = {cmd.a[0], cmd.a[1], cmd.a[2], cmd.a[3]};
        o.y[0] = {cmd.b[0], cmd.b[1], cmd.b[2], cmd.b[3]};
        o.neg[0] = 4'b0111;
        // i lane.
        o.x[1] = {cmd.a[0], cmd.b[0], cmd.a[2], cmd.a[3]};
        o.y[1] = {cmd.b[1], cmd.a[1], cmd.b[3], cmd.b[2]};
        o.neg[1] = 4'b0001;
        // j lane.
        o.x[2] = {cmd.a[0], cmd.b[0], cmd.a[3], cmd.a[1]};
        o.y[2] = {cmd.b[2], cmd.a[2], cmd.b[1], cmd.b[3]};
        o.neg[2] = 4'b0001;
        // k lane.
        o.x[3] = {cmd.a[0], cmd.b[0], cmd.a[1], cmd.a[2]};
        o.y[3] = {cmd.b[3], cmd.a[3], cmd.b[2], cmd.b[1]};
        o.neg[3] = 4'b0001;
      end
      OP_CONJ: begin
        // Components enter as biases at product scale; rounding is exact.
        for (int n = 0; n < 4; n++) begin
          ext = ACC_W'($signed(cmd.a[n]));
          if (n != 0) begin
            ext = -ext;
          end
          o.bias[n] = ext <<< FRAC_BITS;
        end
      end
      OP_ROT: begin
        // Row i of (2r^2-1)I + 2vv^T + 2r[v]x, lane 3 stays zero.
        o.dbl = 1'b1;
        i = int'(row);
        if (i < 3) begin
          nxt = (i == 2) ? 0 : i + 1;
          for (int j = 0; j < 3; j++) begin
            o.x[j][3] = cmd.a[i + 1];
            o.y[j][3] = cmd.a[j + 1];
            o.x[j][2] = cmd.a[0];
            if (i == j) begin
              o.y[j][2] = cmd.a[0];
              o.bias[j] = DIAG_BIAS;
            end else begin
              k = 3 - i - j;
              o.y[j][2] = cmd.a[k + 1];
              o.neg[j][2] = (j == nxt);
            end
          end
        end
      end
      default: begin
        o = '0;
      end
    endcase
    return o;
  endfunction

endpackage

### hw/rtl/qru_queue.sv
// ----------------------------------------------------------------------------
// qru_queue
// Short command queue that decouples the accepting front end from the
// result-producing back end.
// ----------------------------------------------------------------------------
module qru_queue import qru_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t stat
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r;
  logic [Q_PTR_W:0]   count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd  = mem_r[rd_ptr_r];
  assign stat.vld  = (count_r != '0);
  assign stat.full = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));

  // The front end never writes a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("queue written while full");

  // The back end never reads an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.vld)
    else $error("queue read while empty");

  // The pointers stay consistent with the fill count.
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) || (count_r == (Q_PTR_W + 1)'(Q_DEPTH)) |->
      (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");

endmodule

### hw/rtl/qru_front.sv
// ----------------------------------------------------------------------------
// qru_front
// Front end: takes input transactions, drops unused operation codes and
// hands classified commands to the queue.
// ----------------------------------------------------------------------------
module qru_front import qru_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_data,
  output logic     busy,
  input  q_stat_t  q_stat,
  output logic     push,
  output cmd_t     push_cmd
);

  logic f_vld_r;
  logic f_vld_nxt;
  cmd_t f_cmd_r;
  logic take;
  logic known;

  // Holding register drains into the queue whenever there is room.
  assign push = f_vld_r && !q_stat.full;
  assign busy = f_vld_r && q_stat.full;
  assign take = start && !busy;

  // Classification: an unused code is taken but issues nothing.
  always_comb begin
    known     = in_data.func inside {OP_PROD, OP_CONJ, OP_ROT};
    f_vld_nxt = f_vld_r && !push;
    if (take && known) begin
      f_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_cmd_r.op <= op_t'(in_data.func);
      f_cmd_r.a  <= {in_data.a_k, in_data.a_j, in_data.a_i, in_data.a_real};
      f_cmd_r.b  <= {in_data.b_k, in_data.b_j, in_data.b_i, in_data.b_real};
    end
  end

  assign push_cmd = f_cmd_r;

endmodule

### hw/rtl/qru_back.sv
// ----------------------------------------------------------------------------
// qru_back
// Back end: sequences matrix rows, forms operands, multiplies, accumulates,
// rounds and saturates one result per cycle.
// ----------------------------------------------------------------------------
module qru_back import qru_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam logic signed [RND_W-1:0] Q_MAX = RND_W'(32767);
  localparam logic signed [RND_W-1:0] Q_MIN = RND_W'(-32768);

  logic [1:0] row_r;
  logic [1:0] row_nxt;
  logic       is_rot;
  logic       issue_last;
  meta_t      issue_meta;

  logic       a_vld_r;
  opnd_t      a_opnd_r;
  meta_t      a_meta_r;

  logic              b_vld_r;
  logic signed [31:0] b_prod_r [4][4];
  logic [3:0][3:0]   b_neg_r;
  logic              b_dbl_r;
  logic [3:0][ACC_W-1:0] b_bias_r;
  meta_t             b_meta_r;

  logic  c_vld_r;
  acc_t  c_sum_r [4];
  meta_t c_meta_r;
  acc_t  sum_nxt [4];

  logic             d_vld_r;
  out_item_t        d_data_r;
  out_item_t        d_data_nxt;
  logic [3:0][15:0] clip_val;
  logic [3:0]       clip_hit;

  // Row sequencer: a rotation holds the queue head for three rows.
  always_comb begin
    is_rot     = (head_cmd.op == OP_ROT);
    issue_last = !is_rot || (row_r == LAST_ROW);
    pop        = q_stat.vld && issue_last;
    row_nxt    = row_r;
    if (q_stat.vld) begin
      row_nxt = issue_last ? 2'd0 : row_r + 2'd1;
    end
    issue_meta.row  = is_rot ? row_r : 2'd0;
    issue_meta.last = issue_last;
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= 2'd0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      a_vld_r <= q_stat.vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  // Operand selection stage.
  always_ff @(posedge clk) begin
    a_opnd_r <= build_opnd(head_cmd, issue_meta.row);
    a_meta_r <= issue_meta;
  end

  // Multiplier array: sixteen 16x16 signed products.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      for (int t = 0; t < 4; t++) begin
        b_prod_r[l][t] <= $signed(a_opnd_r.x[l][t]) * $signed(a_opnd_r.y[l][t]);
      end
    end
    b_neg_r  <= a_opnd_r.neg;
    b_dbl_r  <= a_opnd_r.dbl;
    b_bias_r <= a_opnd_r.bias;
    b_meta_r <= a_meta_r;
  end

  // Accumulate the signed products of each lane, double, add the bias.
  always_comb begin
    acc_t acc;
    for (int l = 0; l < 4; l++) begin
      acc = '0;
      for (int t = 0; t < 4; t++) begin
        if (b_neg_r[l][t]) begin
          acc = acc - ACC_W'(b_prod_r[l][t]);
        end else begin
          acc = acc + ACC_W'(b_prod_r[l][t]);
        end
      end
      if (b_dbl_r) begin
        acc = acc <<< 1;
      end
      sum_nxt[l] = acc + $signed(b_bias_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      c_sum_r[l] <= sum_nxt[l];
    end
    c_meta_r <= b_meta_r;
  end

  // Round half up to the output step and saturate to 16 bits.
  always_comb begin
    acc_t                     shifted;
    logic signed [RND_W-1:0]  rq;
    for (int l = 0; l < 4; l++) begin
      shifted = (c_sum_r[l] + RND_HALF) >>> FRAC_BITS;
      rq = shifted[RND_W-1:0];
      clip_hit[l] = 1'b1;
      if (rq > Q_MAX) begin
        clip_val[l] = 16'sh7fff;
      end else if (rq < Q_MIN) begin
        clip_val[l] = 16'sh8000;
      end else begin
        clip_val[l] = rq[15:0];
        clip_hit[l] = 1'b0;
      end
    end
    d_data_nxt.out_0     = clip_val[0];
    d_data_nxt.out_1     = clip_val[1];
    d_data_nxt.out_2     = clip_val[2];
    d_data_nxt.out_3     = clip_val[3];
    d_data_nxt.row_index = c_meta_r.row;
    d_data_nxt.last      = c_meta_r.last;
    d_data_nxt.saturated = |clip_hit;
  end

  always_ff @(posedge clk) begin
    d_data_r <= d_data_nxt;
  end

  assign out_valid = d_vld_r;
  assign out_data  = d_data_r;

  // Matrix rows leave back to back, in order.
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.row_index != 2'd0) |->
      $past(out_valid) && ($past(out_data.row_index) == out_data.row_index - 2'd1))
    else $error("matrix row out of sequence");

  // The third matrix row closes its transaction.
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.row_index == LAST_ROW) |-> out_data.last)
    else $error("final matrix row not marked last");

  // A result that is not last is followed at once by the next row.
  a_rows_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("matrix transaction cut short");

endmodule

### hw/rtl/quaternion_rotation_unit_top.sv
// ----------------------------------------------------------------------------
// quaternion_rotation_unit_top
// Quaternion product, conjugate and rotation matrix in Q2.14 fixed point.
//
// Input channel: drive in_data and raise start; the transaction is taken at
// a rising edge where start is high and busy is low. func 0 returns the
// Hamilton product a*b, func 1 the conjugate of a, func 2 the three rows of
// the rotation matrix of a (row_index 0..2, last on row 2); func 3 is taken
// and returns nothing.
// Result channel: each result sits on out_data for exactly one cycle with
// out_valid high; the receiver has no way to stall it.
// The first result passes the front-end holding register, the command queue
// and the operand, product, sum and output registers of the back end.
// Throughput: one product or conjugate per cycle while busy is low; the rows
// of a rotation share the single row datapath of the back end. A four-entry
// command queue absorbs the difference; busy rises only while it is full.
// Reset (rst_n low, synchronous) empties the queue and pipeline; no result
// appears until new transactions arrive.
// ----------------------------------------------------------------------------
module quaternion_rotation_unit_top import qru_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  q_stat_t q_stat;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head_cmd;

  // Accept and classify.
  qru_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue.
  qru_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // Arithmetic pipeline.
  qru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
